FILE: hdl/attractive_potential_force_assert.svh
// Assertion macros for the checker file of this block.
`ifndef ATTRACTIVE_POTENTIAL_FORCE_ASSERT_SVH
`define ATTRACTIVE_POTENTIAL_FORCE_ASSERT_SVH

// Implication in the same cycle, switched off while reset is high.
`define APF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication on the following cycle, active during reset as well.
`define APF_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Types, widths and constants shared by the attractive force pipeline.
// ----------------------------------------------------------------------------
package apf_pkg;

   localparam int AXES   = 6;
   localparam int WORD_W = 32;
   localparam int MAG_W  = 33;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 3;
   localparam int ROOT_W = 35;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 1;
   localparam int Q_W    = 17;
   localparam int FRAC_W = 16;
   localparam int PA_W   = WORD_W + MAG_W;
   localparam int PD_W   = 2 * WORD_W;
   localparam int ACC_W  = 52;

   // Error, square, sum, square root steps, division entry, division steps,
   // multiply, output.
   localparam int LATENCY = 3 + ROOT_W + 1 + Q_W + 2;

   localparam logic [WORD_W-1:0] Z_GOAL     = 32'd26364;
   localparam logic [ROOT_W-1:0] ONE_Q16    = 35'd65536;
   localparam logic [WORD_W-1:0] ATTRACT_RST = 32'd655;
   localparam logic [WORD_W-1:0] DAMPING_RST = 32'd19661;

   typedef enum logic [2:0] {
      CSR_GOAL_X   = 3'd0,
      CSR_GOAL_Y   = 3'd1,
      CSR_GOAL_YAW = 3'd2,
      CSR_ATTRACT  = 3'd3,
      CSR_DAMPING  = 3'd4
   } csr_index_type;

   typedef logic [AXES-1:0][WORD_W-1:0] word_arr_type;

   // Per-item data carried alongside the norm and division stages.
   typedef struct packed {
      logic [AXES-1:0]            neg;
      logic [AXES-1:0][MAG_W-1:0] mag;
      word_arr_type               vel;
      logic                       err_nz;
   } carry_type;

endpackage

FILE: hdl/apf_norm.sv
// ----------------------------------------------------------------------------
// apf_norm
// Error vector, sum of squares and a bit-per-stage square root pipeline.
// ----------------------------------------------------------------------------
module apf_norm import apf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  word_arr_type      pos,
   input  word_arr_type      vel,
   input  logic [WORD_W-1:0] goal_x,
   input  logic [WORD_W-1:0] goal_y,
   input  logic [WORD_W-1:0] goal_yaw,
   output logic              out_valid,
   output carry_type         out_carry,
   output logic [ROOT_W-1:0] out_root
);

   logic                    a_valid_ff, b_valid_ff;
   carry_type               a_carry_ff, a_carry_in, b_carry_ff;
   logic [AXES-1:0][SQ_W-1:0] sq_ff;
   logic [SUM_W-1:0]        sum_in;

   logic              s_valid_ff [ROOT_W+1];
   carry_type         s_carry_ff [ROOT_W+1];
   logic [RAD_W-1:0]  rad_ff     [ROOT_W+1];
   logic [REM_W-1:0]  rem_ff     [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff    [ROOT_W+1];
   logic [REM_W-1:0]  rem_in     [ROOT_W+1];
   logic [ROOT_W-1:0] root_in    [ROOT_W+1];

   always_comb begin
      word_arr_type goal;
      logic [MAG_W-1:0] e;
      goal[0] = goal_x;
      goal[1] = goal_y;
      goal[2] = Z_GOAL;
      goal[3] = '0;
      goal[4] = '0;
      goal[5] = goal_yaw;
      a_carry_in.vel = vel;
      for (int i = 0; i < AXES; i++) begin
         e = {goal[i][WORD_W-1], goal[i]} - {pos[i][WORD_W-1], pos[i]};
         a_carry_in.neg[i] = e[MAG_W-1];
         a_carry_in.mag[i] = e[MAG_W-1] ? (~e + 1'b1) : e;
      end
      a_carry_in.err_nz = |a_carry_in.mag;
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < AXES; i++) begin
         sum_in = sum_in + SUM_W'(sq_ff[i]);
      end
   end

   // One result bit per stage: bring down two radicand bits, try (root<<2)|1.
   always_comb begin
      logic [REM_W+1:0] r2, trial, diff;
      rem_in[0]  = '0;
      root_in[0] = '0;
      for (int k = 0; k < ROOT_W; k++) begin
         r2    = {rem_ff[k], rad_ff[k][RAD_W-1-2*k -: 2]};
         trial = {1'b0, root_ff[k], 2'b01};
         diff  = r2 - trial;
         if (r2 >= trial) begin
            rem_in[k+1]  = diff[REM_W-1:0];
            root_in[k+1] = {root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k+1]  = r2[REM_W-1:0];
            root_in[k+1] = {root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      a_carry_ff <= a_carry_in;
      b_carry_ff <= a_carry_ff;
      for (int i = 0; i < AXES; i++) begin
         sq_ff[i] <= a_carry_ff.mag[i] * a_carry_ff.mag[i];
      end
      s_carry_ff[0] <= b_carry_ff;
      rad_ff[0]     <= RAD_W'(sum_in);
      rem_ff[0]     <= rem_in[0];
      root_ff[0]    <= root_in[0];
      for (int k = 0; k < ROOT_W; k++) begin
         s_carry_ff[k+1] <= s_carry_ff[k];
         rad_ff[k+1]     <= rad_ff[k];
         rem_ff[k+1]     <= rem_in[k+1];
         root_ff[k+1]    <= root_in[k+1];
      end
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         for (int k = 0; k <= ROOT_W; k++) begin
            s_valid_ff[k] <= 1'b0;
         end
      end else begin
         a_valid_ff    <= in_valid;
         b_valid_ff    <= a_valid_ff;
         s_valid_ff[0] <= b_valid_ff;
         for (int k = 0; k < ROOT_W; k++) begin
            s_valid_ff[k+1] <= s_valid_ff[k];
         end
      end
   end

   assign out_valid = s_valid_ff[ROOT_W];
   assign out_carry = s_carry_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];

endmodule

FILE: hdl/apf_div.sv
// ----------------------------------------------------------------------------
// apf_div
// Normalises the error magnitudes by the norm (left as they are when the norm is below one),
// one quotient bit per stage.
module apf_div import apf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  carry_type         in_carry,
   input  logic [ROOT_W-1:0] in_root,
   output logic              out_valid,
   output carry_type         out_carry
);

   logic                           d_valid_ff  [Q_W+1];
   carry_type                      d_carry_ff  [Q_W+1];
   logic [ROOT_W-1:0]              d_root_ff   [Q_W+1];
   logic                           d_bypass_ff [Q_W+1];
   logic [AXES-1:0][ROOT_W-1:0]    d_rem_ff    [Q_W+1];
   logic [AXES-1:0][Q_W-1:0]       d_q_ff      [Q_W+1];
   logic [AXES-1:0][ROOT_W-1:0]    d_rem_in    [Q_W+1];
   logic [AXES-1:0][Q_W-1:0]       d_q_in      [Q_W+1];

   // The quotient never exceeds 2^16 because each magnitude is at most the norm,
   // so the long division starts with the top 32 dividend bits already down.
   always_comb begin
      logic [ROOT_W:0] r2, diff;
      logic            nb;
      for (int i = 0; i < AXES; i++) begin
         d_rem_in[0][i] = ROOT_W'(in_carry.mag[i][MAG_W-1:1]);
         d_q_in[0][i]   = '0;
      end
      for (int j = 0; j < Q_W; j++) begin
         for (int i = 0; i < AXES; i++) begin
            nb   = (j == 0) ? d_carry_ff[j].mag[i][0] : 1'b0;
            r2   = {d_rem_ff[j][i], nb};
            diff = r2 - {1'b0, d_root_ff[j]};
            if (r2 >= {1'b0, d_root_ff[j]}) begin
               d_rem_in[j+1][i] = diff[ROOT_W-1:0];
               d_q_in[j+1][i]   = {d_q_ff[j][i][Q_W-2:0], 1'b1};
            end else begin
               d_rem_in[j+1][i] = r2[ROOT_W-1:0];
               d_q_in[j+1][i]   = {d_q_ff[j][i][Q_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      d_carry_ff[0]  <= in_carry;
      d_root_ff[0]   <= in_root;
      d_bypass_ff[0] <= (in_root < ONE_Q16);
      d_rem_ff[0]    <= d_rem_in[0];
      d_q_ff[0]      <= d_q_in[0];
      for (int j = 0; j < Q_W; j++) begin
         d_carry_ff[j+1]  <= d_carry_ff[j];
         d_root_ff[j+1]   <= d_root_ff[j];
         d_bypass_ff[j+1] <= d_bypass_ff[j];
         d_rem_ff[j+1]    <= d_rem_in[j+1];
         d_q_ff[j+1]      <= d_q_in[j+1];
      end
      if (reset) begin
         for (int j = 0; j <= Q_W; j++) begin
            d_valid_ff[j] <= 1'b0;
         end
      end else begin
         d_valid_ff[0] <= in_valid;
         for (int j = 0; j < Q_W; j++) begin
            d_valid_ff[j+1] <= d_valid_ff[j];
         end
      end
   end

   always_comb begin
      out_carry = d_carry_ff[Q_W];
      if (!d_bypass_ff[Q_W]) begin
         for (int i = 0; i < AXES; i++) begin
            out_carry.mag[i] = MAG_W'(d_q_ff[Q_W][i]);
         end
      end
   end

   assign out_valid = d_valid_ff[Q_W];

endmodule

FILE: hdl/apf_scale.sv
// ----------------------------------------------------------------------------
// apf_scale
// Gain products, floor rounding, damping subtraction and saturation.
// ----------------------------------------------------------------------------
module apf_scale import apf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  carry_type         in_carry,
   input  logic [WORD_W-1:0] attract_gain,
   input  logic [WORD_W-1:0] damping_gain,
   output logic              out_valid,
   output word_arr_type      out_force,
   output logic              out_local_minimum
);

   logic                      m_valid_ff, f_valid_ff;
   logic                      m_err_nz_ff;
   logic [AXES-1:0]           m_neg_a_ff, m_neg_d_ff;
   logic [AXES-1:0][PA_W-1:0] pa_ff;
   logic [AXES-1:0][PD_W-1:0] pd_ff;
   word_arr_type              force_ff, force_in;
   logic                      lmin_ff, lmin_in;
   word_arr_type              vmag_in;

   // Velocity magnitudes, formed at the word width before they reach the multiplier.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         vmag_in[i] = in_carry.vel[i][WORD_W-1] ? (~in_carry.vel[i] + 1'b1)
                                                : in_carry.vel[i];
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] a, d, f;
      logic [ACC_W-1:0]        ta, td;
      ta = '0;
      td = '0;
      for (int i = 0; i < AXES; i++) begin
         ta = ACC_W'(pa_ff[i][PA_W-1:FRAC_W]) + ACC_W'(|pa_ff[i][FRAC_W-1:0]);
         td = ACC_W'(pd_ff[i][PD_W-1:FRAC_W]) + ACC_W'(|pd_ff[i][FRAC_W-1:0]);
         a  = m_neg_a_ff[i] ? -$signed(ta) : $signed(ACC_W'(pa_ff[i][PA_W-1:FRAC_W]));
         d  = m_neg_d_ff[i] ? -$signed(td) : $signed(ACC_W'(pd_ff[i][PD_W-1:FRAC_W]));
         f  = a - d;
         if (f > $signed(ACC_W'(32'h7FFF_FFFF))) begin
            force_in[i] = 32'h7FFF_FFFF;
         end else if (f < -$signed(ACC_W'(33'h1_0000_0000 >> 1))) begin
            force_in[i] = 32'h8000_0000;
         end else begin
            force_in[i] = f[WORD_W-1:0];
         end
      end
      lmin_in = m_err_nz_ff && (force_in == '0);
   end

   always_ff @(posedge clock) begin
      m_err_nz_ff <= in_carry.err_nz;
      for (int i = 0; i < AXES; i++) begin
         m_neg_a_ff[i] <= in_carry.neg[i];
         m_neg_d_ff[i] <= in_carry.vel[i][WORD_W-1];
         pa_ff[i] <= attract_gain * in_carry.mag[i];
         pd_ff[i] <= damping_gain * vmag_in[i];
      end
      force_ff <= force_in;
      lmin_ff  <= lmin_in;
      if (reset) begin
         m_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= in_valid;
         f_valid_ff <= m_valid_ff;
      end
   end

   assign out_valid         = f_valid_ff;
   assign out_force         = force_ff;
   assign out_local_minimum = lmin_ff;

endmodule

FILE: hdl/attractive_potential_force.sv
// ----------------------------------------------------------------------------
// attractive_potential_force
// Attractive potential-field force with velocity damping, fully pipelined.
// ----------------------------------------------------------------------------
// A pose and velocity are taken whenever start is high; busy is always low, so
// a new transaction may be issued on every clock cycle.
// Each transaction yields one result, shown for one cycle with rsp_valid high.
// The pipeline holds the square root of the error norm (35 stages, one
// result bit each) and the normalising division (an entry stage and 17
// stages, one quotient bit each), plus error, square, sum, multiply and
// output stages. The receiver cannot stall; results are never held back.
// Registers are written over the csr_ channel, which is always ready; writes
// to indexes beyond the register list are dropped. Registers should only be
// changed while no transaction is in flight.
// Synchronous reset empties the pipeline and restores the goal (zero) and the
// default gains.
// ----------------------------------------------------------------------------
module attractive_potential_force import apf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_roll_now,
   input  logic [31:0] req_pitch_now,
   input  logic [31:0] req_yaw_now,
   input  logic [31:0] req_vel_x,
   input  logic [31:0] req_vel_y,
   input  logic [31:0] req_vel_z,
   input  logic [31:0] req_vel_roll,
   input  logic [31:0] req_vel_pitch,
   input  logic [31:0] req_vel_yaw,
   output logic        rsp_valid,
   output logic [31:0] rsp_force_x,
   output logic [31:0] rsp_force_y,
   output logic [31:0] rsp_force_z,
   output logic [31:0] rsp_force_roll,
   output logic [31:0] rsp_force_pitch,
   output logic [31:0] rsp_force_yaw,
   output logic        rsp_local_minimum,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [WORD_W-1:0] goal_x_ff, goal_y_ff, goal_yaw_ff, attract_ff, damping_ff;
   word_arr_type      pos, vel, force_vec;
   logic              n_valid, d_valid;
   carry_type         n_carry, d_carry;
   logic [ROOT_W-1:0] n_root;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         goal_yaw_ff <= '0;
         attract_ff  <= ATTRACT_RST;
         damping_ff  <= DAMPING_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GOAL_X:   goal_x_ff   <= csr_data;
            CSR_GOAL_Y:   goal_y_ff   <= csr_data;
            CSR_GOAL_YAW: goal_yaw_ff <= csr_data;
            CSR_ATTRACT:  attract_ff  <= csr_data;
            CSR_DAMPING:  damping_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign pos = {req_yaw_now, req_pitch_now, req_roll_now,
                 req_pos_z, req_pos_y, req_pos_x};
   assign vel = {req_vel_yaw, req_vel_pitch, req_vel_roll,
                 req_vel_z, req_vel_y, req_vel_x};

   apf_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .pos      (pos),
      .vel      (vel),
      .goal_x   (goal_x_ff),
      .goal_y   (goal_y_ff),
      .goal_yaw (goal_yaw_ff),
      .out_valid(n_valid),
      .out_carry(n_carry),
      .out_root (n_root)
   );

   apf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (n_valid),
      .in_carry (n_carry),
      .in_root  (n_root),
      .out_valid(d_valid),
      .out_carry(d_carry)
   );

   apf_scale u_scale (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (d_valid),
      .in_carry         (d_carry),
      .attract_gain     (attract_ff),
      .damping_gain     (damping_ff),
      .out_valid        (rsp_valid),
      .out_force        (force_vec),
      .out_local_minimum(rsp_local_minimum)
   );

   assign rsp_force_x     = force_vec[0];
   assign rsp_force_y     = force_vec[1];
   assign rsp_force_z     = force_vec[2];
   assign rsp_force_roll  = force_vec[3];
   assign rsp_force_pitch = force_vec[4];
   assign rsp_force_yaw   = force_vec[5];

endmodule

FILE: hdl/apf_checker.sv
// ----------------------------------------------------------------------------
// apf_checker
// Port-level checks on result timing, the local minimum flag and the reset flush.
// ----------------------------------------------------------------------------
`include "attractive_potential_force_assert.svh"

module apf_checker import apf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_force_x,
   input logic [31:0] rsp_force_y,
   input logic [31:0] rsp_force_z,
   input logic [31:0] rsp_force_roll,
   input logic [31:0] rsp_force_pitch,
   input logic [31:0] rsp_force_yaw,
   input logic        rsp_local_minimum
);

   logic zero_force;

   assign zero_force = (rsp_force_x == 32'd0) && (rsp_force_y == 32'd0) &&
                       (rsp_force_z == 32'd0) && (rsp_force_roll == 32'd0) &&
                       (rsp_force_pitch == 32'd0) && (rsp_force_yaw == 32'd0);

   // A result only ever appears a fixed pipeline depth after a transaction.
   `APF_ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, LATENCY))
   `APF_ASSERT_IMPL(a_lmin_zero, clock, reset, rsp_valid && rsp_local_minimum, zero_force)
   `APF_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind attractive_potential_force apf_checker u_apf_checker (.*);
